### rtl/core/assert_macros.svh
// Assertion macros shared by the forwarder RTL.
// Self-contained; no dependencies on other files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define LBF_ASSERT_SAME(lbl, clk_s, rst_s, trig, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LBF_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |=> (cond)) \
    else $error(msg);

`endif

### rtl/core/lbf_pkg.sv
// Shared types, constants and command/status structs for the learning bridge forwarder.
// No dependencies; imported by every module of the block.
package lbf_pkg;

  localparam int ACCESS_PORTS  = 8;
  localparam int TABLE_ENTRIES = 64;
  localparam int MAC_BYTES     = 6;

  localparam int MAC_W   = 8 * MAC_BYTES;
  localparam int PORT_W  = 4;
  localparam int TYPE_W  = 3;
  localparam int MASK_W  = 8;
  localparam int VERD_W  = 2;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  // Access ports that a mask bit can reach.
  localparam int EN_W       = (ACCESS_PORTS < MASK_W) ? ACCESS_PORTS : MASK_W;
  localparam int PORT_SLOTS = 2 ** PORT_W;

  localparam logic [PORT_W-1:0] TRUNK_PORT = '0;

  localparam logic [TYPE_W-1:0] TYPE_BROADCAST = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_MULTICAST = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_OTHERHOST = 3'd3;

  localparam logic [VERD_W-1:0] VERDICT_OK          = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_UNKNOWN     = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_UNSUPPORTED = 2'd2;
  localparam logic [VERD_W-1:0] VERDICT_NO_PORT     = 2'd3;

  typedef struct packed {
    logic [PORT_W-1:0] src_port;
    logic [TYPE_W-1:0] pkt_type;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0] out_port;
    logic              forward;
    logic [VERD_W-1:0] verdict;
    logic              learned;
    logic              table_full;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } host_entry_t;

  typedef enum logic [2:0] {
    RES_UNSUPPORTED,
    RES_NO_PORT,
    RES_UNKNOWN,
    RES_UNICAST,
    RES_TRUNK,
    RES_FLOOD
  } result_kind_t;

  typedef struct packed {
    logic         load;
    logic         search_start;
    logic         search_step;
    logic         learn;
    logic         flood_start;
    logic         flood_next;
    logic         emit;
    result_kind_t kind;
  } lbf_cmd_t;

  typedef struct packed {
    logic unsupported;
    logic from_trunk;
    logic flood;
    logic any_enabled;
    logic search_done;
    logic found;
    logic found_port_en;
    logic flood_cur_en;
    logic flood_last;
    logic out_free;
  } lbf_status_t;

endpackage

### rtl/core/lbf_datapath.sv
// Datapath: frame register, host table memory with its search and learn logic,
// flood port counter, enable mask and output register. Depends on lbf_pkg.
module lbf_datapath import lbf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  in_item_t            in_data,
  input  logic                cfg_wr_en,
  input  logic [MASK_W-1:0]   cfg_wr_data,
  input  lbf_cmd_t            cmd,
  output lbf_status_t         status,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  host_entry_t host_mem [TABLE_ENTRIES];

  in_item_t            item;
  host_entry_t         rd_entry;
  logic                rd_pending;
  logic [CNT_W-1:0]    search_idx;
  logic [CNT_W-1:0]    fill_count;
  logic                found;
  logic [PORT_W-1:0]   found_port;
  logic                learned_flag;
  logic                full_flag;
  logic [PORT_W-1:0]   flood_port;
  logic [MASK_W-1:0]   port_mask;

  logic [MAC_W-1:0]      search_key;
  logic [PORT_SLOTS-1:0] port_en;
  logic [PORT_SLOTS-1:0] higher_ports;
  logic                  idx_in_use;
  logic                  has_room;
  logic                  is_flood;
  out_item_t             result_next;

  // Bit p of port_en stands for port p; the trunk and unreachable ports read as off.
  assign port_en      = {{(PORT_SLOTS - EN_W - 1){1'b0}}, port_mask[EN_W-1:0], 1'b0};
  assign higher_ports = (port_en >> flood_port) >> 1;
  assign search_key   = (item.src_port == TRUNK_PORT) ? item.dst_mac : item.src_mac;
  assign idx_in_use   = (search_idx < fill_count);
  assign has_room     = (fill_count < CNT_W'(TABLE_ENTRIES));
  assign is_flood     = (item.pkt_type == TYPE_BROADCAST) ||
                        (item.pkt_type == TYPE_MULTICAST);

  always_comb begin
    status.flood         = is_flood;
    status.from_trunk    = (item.src_port == TRUNK_PORT);
    status.unsupported   = !(is_flood || item.pkt_type == TYPE_OTHERHOST) ||
                           (item.src_port > PORT_W'(ACCESS_PORTS));
    status.any_enabled   = (port_en != '0);
    status.search_done   = found || (!rd_pending && !idx_in_use);
    status.found         = found;
    status.found_port_en = port_en[found_port];
    status.flood_cur_en  = port_en[flood_port];
    status.flood_last    = (higher_ports == '0);
    status.out_free      = !out_valid || !out_stall;
  end

  // Entries are filled in order and never removed, so an entry is valid
  // exactly when its index lies below the fill count.
  always_ff @(posedge clk) begin
    if (cmd.learn && !found && has_room) begin
      host_mem[fill_count[IDX_W-1:0]] <= '{mac: item.src_mac, port: item.src_port};
    end
    if (cmd.search_step && idx_in_use) begin
      rd_entry <= host_mem[search_idx[IDX_W-1:0]];
    end
  end

  // Only the first matching entry sets the port; later reads must not disturb it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.search_step && rd_pending && !found && rd_entry.mac == search_key) begin
      found_port <= rd_entry.port;
    end
    if (cmd.emit) begin
      out_data <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_mask    <= '0;
      fill_count   <= '0;
      search_idx   <= '0;
      rd_pending   <= 1'b0;
      found        <= 1'b0;
      learned_flag <= 1'b0;
      full_flag    <= 1'b0;
      flood_port   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        port_mask <= cfg_wr_data;
      end
      if (cmd.load) begin
        learned_flag <= 1'b0;
        full_flag    <= 1'b0;
      end
      if (cmd.search_start) begin
        search_idx <= '0;
        rd_pending <= 1'b0;
        found      <= 1'b0;
      end else if (cmd.search_step) begin
        if (idx_in_use) begin
          search_idx <= CNT_W'(search_idx + 1'b1);
        end
        rd_pending <= idx_in_use;
        if (rd_pending && rd_entry.mac == search_key) begin
          found <= 1'b1;
        end
      end
      if (cmd.learn && !found) begin
        if (has_room) begin
          fill_count   <= CNT_W'(fill_count + 1'b1);
          learned_flag <= 1'b1;
        end else begin
          full_flag <= 1'b1;
        end
      end
      if (cmd.flood_start) begin
        flood_port <= PORT_W'(1);
      end else if (cmd.flood_next) begin
        flood_port <= PORT_W'(flood_port + 1'b1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    result_next = '{out_port: TRUNK_PORT, forward: 1'b0, verdict: VERDICT_OK,
                    learned: 1'b0, table_full: 1'b0, last_result: 1'b1};
    unique case (cmd.kind)
      RES_UNSUPPORTED: result_next.verdict = VERDICT_UNSUPPORTED;
      RES_NO_PORT:     result_next.verdict = VERDICT_NO_PORT;
      RES_UNKNOWN:     result_next.verdict = VERDICT_UNKNOWN;
      RES_UNICAST: begin
        result_next.out_port = found_port;
        result_next.forward  = 1'b1;
      end
      RES_TRUNK: begin
        result_next.forward    = 1'b1;
        result_next.learned    = learned_flag;
        result_next.table_full = full_flag;
      end
      RES_FLOOD: begin
        result_next.out_port    = flood_port;
        result_next.forward     = 1'b1;
        result_next.last_result = status.flood_last;
      end
      default: result_next.verdict = VERDICT_UNSUPPORTED;
    endcase
  end

endmodule

### rtl/core/lbf_ctrl.sv
// Controller state machine: sequences classification, table search, learning,
// flooding and result issue. Depends on lbf_pkg.
module lbf_ctrl import lbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  lbf_status_t status,
  output lbf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_SEARCH,
    S_EMIT,
    S_FLOOD
  } state_t;

  state_t       state;
  state_t       state_next;
  result_kind_t kind;
  result_kind_t kind_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.kind   = kind;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        priority if (status.unsupported) begin
          kind_next  = RES_UNSUPPORTED;
          state_next = S_EMIT;
        end else if (status.from_trunk && status.flood) begin
          if (!status.any_enabled) begin
            kind_next  = RES_NO_PORT;
            state_next = S_EMIT;
          end else begin
            cmd.flood_start = 1'b1;
            state_next      = S_FLOOD;
          end
        end else begin
          cmd.search_start = 1'b1;
          state_next       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_done) begin
          state_next = S_EMIT;
          priority if (!status.from_trunk) begin
            cmd.learn = 1'b1;
            kind_next = RES_TRUNK;
          end else if (!status.found) begin
            kind_next = RES_UNKNOWN;
          end else if (!status.found_port_en) begin
            kind_next = RES_NO_PORT;
          end else begin
            kind_next = RES_UNICAST;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLOOD: begin
        cmd.kind = RES_FLOOD;
        // Disabled ports are stepped over without waiting for the output.
        if (!status.flood_cur_en) begin
          cmd.flood_next = 1'b1;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.flood_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.flood_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RES_UNSUPPORTED;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

### rtl/core/learning_bridge_forwarder_core.sv
// Top level of the learning bridge forwarder: controller plus datapath.
// Depends on lbf_pkg, lbf_ctrl, lbf_datapath and assert_macros.svh.
//
//   Channel   Handshake                     Payload
//   in        in_valid / in_stall           in_data  (in_item_t)
//   out       out_valid / out_stall         out_data (out_item_t)
//   cfg       cfg_wr_en                     cfg_wr_data (port enable mask)
//
// One frame is handled at a time. A table search reads one entry a cycle from
// the single-port host table, so the time for a trunk unicast or an access-port
// frame grows with the fill count. A flood steps through each access port up to
// the last enabled one. Reset clears the control state, the enable mask and the
// fill count; the table needs no clearing pass. A stalled output holds its
// transaction, and the next frame is taken as soon as the last result is in the
// output register.
`include "assert_macros.svh"

module learning_bridge_forwarder_core import lbf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [MASK_W-1:0] cfg_wr_data
);

  lbf_cmd_t    cmd;
  lbf_status_t status;
  logic        out_leaves;
  logic        flood_hop;

  lbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lbf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  assign out_leaves = out_valid && !out_stall && !cmd.emit;
  assign flood_hop  = cmd.flood_next && status.flood_cur_en;

  `LBF_ASSERT_SAME(a_emit_room, clk, rst, cmd.emit, status.out_free, "issue into a full output")
  `LBF_ASSERT_SAME(a_learn_done, clk, rst, cmd.learn, status.search_done, "early learning")
  `LBF_ASSERT_NEXT(a_out_drains, clk, rst, out_leaves, !out_valid, "output held after take")
  `LBF_ASSERT_SAME(a_flood_end, clk, rst, flood_hop, !status.flood_last, "flood overran")

endmodule
